>>> rtl/core/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg: shared types and constants of the scan resistant LRU replacer
// Field widths, action codes, register map and the order update command.
// ----------------------------------------------------------------------------
package scr_pkg;

   // default configuration of the slot order and the block size
   localparam int NUM_SLOTS_DEFAULT   = 16;
   localparam int BLOCK_SHIFT_DEFAULT = 3;

   // fixed field widths
   localparam int SECTOR_W = 48;
   localparam int SLOT_W   = 4;
   localparam int CSEC_W   = 7;
   localparam int RUN_W    = 8;

   // request kinds
   localparam logic REQ_HIT  = 1'b0;
   localparam logic REQ_MISS = 1'b1;

   // run length limits
   localparam logic [RUN_W-1:0] RUN_MAX   = 8'hFF;
   localparam logic [RUN_W-1:0] RUN_FIRST = 8'd1;

   // register map: one register per 32-bit word
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_SCAN_THRESHOLD = 1'b0;
   localparam logic [RUN_W-1:0]     THRESHOLD_RESET    = 8'd10;

   // result actions
   typedef enum logic [1:0] {
      ACT_READ_CACHE = 2'd0,
      ACT_BYPASS     = 2'd1,
      ACT_FILL       = 2'd2
   } action_type;

   // order update command from the request stage
   typedef struct packed {
      logic              hit;
      logic              fill;
      logic [SLOT_W-1:0] hit_slot;
   } order_cmd_type;

endpackage

>>> rtl/core/scr_csr.sv
// ----------------------------------------------------------------------------
// scr_csr: configuration registers
// APB-style slave holding the scan threshold.
// ----------------------------------------------------------------------------
module scr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [scr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output logic [scr_pkg::RUN_W-1:0]     threshold
);
   import scr_pkg::*;

   logic [RUN_W-1:0]     threshold_ff;
   logic [RUN_W-1:0]     threshold_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_beat;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_beat = psel && penable && pwrite && pready;

   // register write
   always_comb begin
      threshold_in = threshold_ff;
      if (wr_beat && (reg_idx == REG_SCAN_THRESHOLD)) begin
         threshold_in = pwdata[RUN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (reg_idx == REG_SCAN_THRESHOLD) begin
         prdata = {{(32 - RUN_W){1'b0}}, threshold_ff};
      end
   end

   assign threshold = threshold_ff;

endmodule

>>> rtl/core/scr_scan_det.sv
// ----------------------------------------------------------------------------
// scr_scan_det: sequential scan detector
// Counts consecutive misses one block apart and flags misses to bypass.
// ----------------------------------------------------------------------------
module scr_scan_det #(
   parameter int BLOCK_SHIFT_BITS = scr_pkg::BLOCK_SHIFT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          miss_valid,
   input  logic [scr_pkg::SECTOR_W-1:0]  sector,
   input  logic [scr_pkg::RUN_W-1:0]     threshold,
   output logic                          bypass,
   output logic [scr_pkg::RUN_W-1:0]     run_now
);
   import scr_pkg::*;

   localparam logic [SECTOR_W-1:0] STEP = SECTOR_W'(1) << BLOCK_SHIFT_BITS;

   logic [SECTOR_W-1:0] last_ff;
   logic [SECTOR_W-1:0] last_in;
   logic [RUN_W-1:0]    run_ff;
   logic [RUN_W-1:0]    run_in;
   logic                have_prev_ff;
   logic                have_prev_in;
   logic                in_step;
   logic [RUN_W-1:0]    run_next;

   // next run length for a miss, step taken modulo the sector width
   assign in_step = (sector == (last_ff + STEP));

   always_comb begin
      if (!have_prev_ff) begin
         run_next = RUN_FIRST;
      end else if (in_step) begin
         run_next = (run_ff == RUN_MAX) ? RUN_MAX : run_ff + RUN_W'(1);
      end else begin
         run_next = RUN_FIRST;
      end
   end

   // first miss after reset never bypasses
   assign bypass  = miss_valid && have_prev_ff && (run_next >= threshold);
   assign run_now = miss_valid ? run_next : run_ff;

   // detector state
   always_comb begin
      last_in      = last_ff;
      run_in       = run_ff;
      have_prev_in = have_prev_ff;
      if (miss_valid) begin
         last_in      = sector;
         run_in       = run_next;
         have_prev_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= '0;
         run_ff       <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         last_ff      <= last_in;
         run_ff       <= run_in;
         have_prev_ff <= have_prev_in;
      end
   end

   // a run is open exactly once a miss has been seen
   a_run_open : assert property (@(posedge clock) disable iff (reset)
      have_prev_ff == (run_ff != '0))
      else $error("scan run length out of step with miss history");

endmodule

>>> rtl/core/scr_order.sv
// ----------------------------------------------------------------------------
// scr_order: recency order of the cache slots
// Row of slot cells; a promote moves one entry to the most recent end and
// shifts the entries above it down by one, all in a single update.
// ----------------------------------------------------------------------------
module scr_order #(
   parameter int NUM_SLOTS = scr_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  scr_pkg::order_cmd_type        cmd,
   output logic [$clog2(NUM_SLOTS)-1:0]  victim
);
   import scr_pkg::*;

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

   logic [IDX_W-1:0]     order_ff [NUM_SLOTS];
   logic [IDX_W-1:0]     order_in [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] match;
   logic [NUM_SLOTS-1:0] ge;
   logic [IDX_W-1:0]     moved;
   logic [CMP_W-1:0]     slot_ext;

   assign slot_ext = CMP_W'(cmd.hit_slot);

   // locate the entry to promote; the least recent one on a fill
   always_comb begin
      moved = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         match[i] = (cmd.hit && (CMP_W'(order_ff[i]) == slot_ext)) ||
                    (cmd.fill && (i == 0));
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (match[i]) begin
            moved = moved | order_ff[i];
         end
      end
   end

   // each cell at or above the promoted place takes its upper neighbour
   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      assign ge[i] = |match[i:0];
      if (i == NUM_SLOTS - 1) begin : g_top
         assign order_in[i] = ge[i] ? moved : order_ff[i];
      end else begin : g_mid
         assign order_in[i] = ge[i] ? order_ff[i+1] : order_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            order_ff[i] <= IDX_W'(i);
         end
      end else begin
         order_ff <= order_in;
      end
   end

   assign victim = order_ff[0];

   // the order stays a permutation, so at most one cell matches
   a_one_match : assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("more than one order entry matches the promoted slot");

endmodule

>>> rtl/core/scan_resistant_lru_replacer.sv
// ----------------------------------------------------------------------------
// scan_resistant_lru_replacer: LRU slot replacer with scan bypass
// Top level: request register, scan detector, slot order, result register.
// ----------------------------------------------------------------------------
// A request is taken at every clock edge with start high; busy stays low, so
// one request per cycle is sustained. The request is registered, and in the
// following cycle the scan detector and the slot order are updated and the
// result is registered; rsp_valid comes from that result register. Requests
// are served strictly in order, and each one sees the order and run length
// left by the one before it. The receiver cannot hold results off. There is
// no clearing pass after reset. The scan threshold sits at byte address 0 of
// the APB-style port.
// ----------------------------------------------------------------------------
module scan_resistant_lru_replacer #(
   parameter int NUM_SLOTS        = scr_pkg::NUM_SLOTS_DEFAULT,
   parameter int BLOCK_SHIFT_BITS = scr_pkg::BLOCK_SHIFT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // request beat
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_type,
   input  logic [scr_pkg::SLOT_W-1:0]     req_hit_slot,
   input  logic [scr_pkg::SECTOR_W-1:0]   req_src_sector,
   // result beat
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_action,
   output logic [scr_pkg::SLOT_W-1:0]     rsp_slot,
   output logic [scr_pkg::CSEC_W-1:0]     rsp_cache_sector,
   output logic [scr_pkg::RUN_W-1:0]      rsp_scan_run,
   // configuration
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [scr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import scr_pkg::*;

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam int SH_W  = CMP_W + BLOCK_SHIFT_BITS + CSEC_W;

   // request register
   logic                req_valid_ff;
   logic                req_type_ff;
   logic [SLOT_W-1:0]   req_slot_ff;
   logic [SECTOR_W-1:0] req_sector_ff;

   // result register
   logic                rsp_valid_ff;
   action_type          rsp_action_ff;
   action_type          rsp_action_in;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [SLOT_W-1:0]   rsp_slot_in;
   logic [CSEC_W-1:0]   rsp_csec_ff;
   logic [CSEC_W-1:0]   rsp_csec_in;
   logic [RUN_W-1:0]    rsp_run_ff;

   logic [RUN_W-1:0]    threshold;
   logic                miss_valid;
   logic                bypass;
   logic [RUN_W-1:0]    run_now;
   order_cmd_type       order_cmd;
   logic [IDX_W-1:0]    victim;
   logic [CMP_W-1:0]    sel_slot;
   logic [SH_W-1:0]     shifted;

   assign busy = 1'b0;

   // capture the request beat
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff   <= req_type;
      req_slot_ff   <= req_hit_slot;
      req_sector_ff <= req_src_sector;
   end

   scr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .threshold (threshold)
   );

   assign miss_valid = req_valid_ff && (req_type_ff == REQ_MISS);

   scr_scan_det #(
      .BLOCK_SHIFT_BITS (BLOCK_SHIFT_BITS)
   ) u_scan_det (
      .clock      (clock),
      .reset      (reset),
      .miss_valid (miss_valid),
      .sector     (req_sector_ff),
      .threshold  (threshold),
      .bypass     (bypass),
      .run_now    (run_now)
   );

   // order update: promote on a hit, evict least recent on a fill
   always_comb begin
      order_cmd.hit      = req_valid_ff && (req_type_ff == REQ_HIT);
      order_cmd.fill     = miss_valid && !bypass;
      order_cmd.hit_slot = req_slot_ff;
   end

   scr_order #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_order (
      .clock  (clock),
      .reset  (reset),
      .cmd    (order_cmd),
      .victim (victim)
   );

   // result fields
   assign sel_slot = (req_type_ff == REQ_HIT) ? CMP_W'(req_slot_ff) : CMP_W'(victim);
   assign shifted  = SH_W'(sel_slot) << BLOCK_SHIFT_BITS;

   always_comb begin
      if (req_type_ff == REQ_HIT) begin
         rsp_action_in = ACT_READ_CACHE;
         rsp_slot_in   = sel_slot[SLOT_W-1:0];
         rsp_csec_in   = shifted[CSEC_W-1:0];
      end else if (bypass) begin
         rsp_action_in = ACT_BYPASS;
         rsp_slot_in   = '0;
         rsp_csec_in   = '0;
      end else begin
         rsp_action_in = ACT_FILL;
         rsp_slot_in   = sel_slot[SLOT_W-1:0];
         rsp_csec_in   = shifted[CSEC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_action_ff <= rsp_action_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_csec_ff   <= rsp_csec_in;
      rsp_run_ff    <= run_now;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = rsp_action_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_cache_sector = rsp_csec_ff;
   assign rsp_scan_run     = rsp_run_ff;

   // every registered request leaves exactly one result beat
   a_req_to_rsp : assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> rsp_valid_ff)
      else $error("registered request produced no result beat");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |=> !rsp_valid_ff)
      else $error("result beat without a request");

   // a bypassed miss names no slot
   a_bypass_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_action_ff == ACT_BYPASS)) |->
      ((rsp_slot_ff == '0) && (rsp_csec_ff == '0)))
      else $error("bypass result carries a slot");

endmodule
